FILE: hdl/mrtu_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU
// register access unit. No dependencies.

package mrtu_pkg;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [7:0]  FUNC_WRITE = 8'h06;
   localparam logic [7:0]  BYTE_COUNT = 8'h02;
   localparam logic [7:0]  READ_QTY_HI = 8'h00;
   localparam logic [7:0]  READ_QTY_LO = 8'h01;

   // frame byte positions
   localparam logic [2:0] POS_ADDR   = 3'd0;
   localparam logic [2:0] POS_FUNC   = 3'd1;
   localparam logic [2:0] POS_REG_HI = 3'd2;
   localparam logic [2:0] POS_REG_LO = 3'd3;
   localparam logic [2:0] POS_VAL_HI = 3'd4;
   localparam logic [2:0] POS_VAL_LO = 3'd5;
   localparam logic [2:0] POS_CRC_LO = 3'd6;
   localparam logic [2:0] POS_CRC_HI = 3'd7;

   // read reply byte positions
   localparam logic [2:0] RPL_CRC_LO = 3'd5;
   localparam logic [2:0] RPL_LAST   = 3'd6;
   localparam int         REPLY_STORE = 6;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_RX    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CRC_ERROR = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   typedef logic [7:0][7:0] frame_type;

   typedef struct packed {
      logic       start;
      logic       start_write;
      logic       rx_strobe;
      logic [7:0] rx_byte;
   } reply_ctrl_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [15:0] value;
   } reply_done_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: hdl/mrtu_req_if.sv
// Request channel: valid/ready word with action and request or line byte fields.
// No dependencies.

interface mrtu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  server_address;
   logic [15:0] register_address;
   logic [15:0] write_value;
   logic [7:0]  rx_byte;

   modport source (output valid, action, server_address, register_address, write_value,
                   rx_byte, input ready);
   modport sink   (input valid, action, server_address, register_address, write_value,
                   rx_byte, output ready);
endinterface

FILE: hdl/mrtu_rsp_if.sv
// Result channel: valid/ready word carrying a frame byte or a completion.
// No dependencies.

interface mrtu_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  tx_byte;
   logic        frame_last;
   logic [1:0]  status;
   logic [15:0] read_value;

   modport source (output valid, kind, tx_byte, frame_last, status, read_value, input ready);
   modport sink   (input valid, kind, tx_byte, frame_last, status, read_value, output ready);
endinterface

FILE: hdl/mrtu_reply_chk.sv
// Reply checker: collects line bytes of a pending reply and flags completion.
// Depends on mrtu_pkg.

module mrtu_reply_chk (
   input  logic                    clock,
   input  logic                    reset,
   input  mrtu_pkg::reply_ctrl_type ctrl,
   input  mrtu_pkg::frame_type      sent_frame,
   output mrtu_pkg::reply_done_type done
);

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [2:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        mismatch_ff, mismatch_in;
   logic [mrtu_pkg::REPLY_STORE-1:0][7:0] bytes_ff, bytes_in;

   logic [15:0] got_crc;

   assign got_crc = {ctrl.rx_byte, bytes_ff[mrtu_pkg::RPL_CRC_LO]};

   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      mismatch_in = mismatch_ff;
      bytes_in    = bytes_ff;
      done        = '0;
      done.status = mrtu_pkg::STATUS_OK;
      if (ctrl.start) begin
         mode_in     = ctrl.start_write ? MODE_WRITE : MODE_READ;
         count_in    = '0;
         crc_in      = mrtu_pkg::CRC_INIT;
         mismatch_in = 1'b0;
      end else if (ctrl.rx_strobe) begin
         case (mode_ff)
            MODE_READ: begin
               if (count_ff < 3'(mrtu_pkg::REPLY_STORE)) begin
                  bytes_in[count_ff] = ctrl.rx_byte;
               end
               if (count_ff < mrtu_pkg::RPL_CRC_LO) begin
                  crc_in = mrtu_pkg::crc_byte(crc_ff, ctrl.rx_byte);
               end
               count_in = count_ff + 3'd1;
               if (count_ff == mrtu_pkg::RPL_LAST) begin
                  done.valid = 1'b1;
                  // CRC is checked before the header fields
                  if (got_crc != crc_ff) begin
                     done.status = mrtu_pkg::STATUS_CRC_ERROR;
                  end else if (bytes_ff[0] != sent_frame[mrtu_pkg::POS_ADDR] ||
                               bytes_ff[1] != sent_frame[mrtu_pkg::POS_FUNC] ||
                               bytes_ff[2] != mrtu_pkg::BYTE_COUNT) begin
                     done.status = mrtu_pkg::STATUS_INVALID;
                  end else begin
                     done.value = {bytes_ff[3], bytes_ff[4]};
                  end
                  mode_in  = MODE_IDLE;
                  count_in = '0;
                  crc_in   = mrtu_pkg::CRC_INIT;
               end
            end
            MODE_WRITE: begin
               mismatch_in = mismatch_ff | (ctrl.rx_byte != sent_frame[count_ff]);
               count_in    = count_ff + 3'd1;
               if (count_ff == mrtu_pkg::POS_CRC_HI) begin
                  done.valid  = 1'b1;
                  done.status = mismatch_in ? mrtu_pkg::STATUS_INVALID : mrtu_pkg::STATUS_OK;
                  mode_in     = MODE_IDLE;
                  count_in    = '0;
                  mismatch_in = 1'b0;
               end
            end
            default: begin
               // idle: line bytes are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         count_ff    <= '0;
         crc_ff      <= mrtu_pkg::CRC_INIT;
         mismatch_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         mismatch_ff <= mismatch_in;
      end
      bytes_ff <= bytes_in;
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      done.valid |=> mode_ff == MODE_IDLE && count_ff == 3'd0)
      else $error("reply checker did not return to idle after completion");

   a_read_count_bound: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_READ |-> count_ff <= mrtu_pkg::RPL_LAST)
      else $error("read reply count past last byte");

   a_idle_no_done: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE && !ctrl.start |-> !done.valid)
      else $error("completion while no reply pending");

endmodule

FILE: hdl/modbus_rtu_master_register_access_unit.sv
// Top level of the Modbus RTU single-register master: frame sequencer and result register.
// Depends on mrtu_pkg, mrtu_req_if, mrtu_rsp_if and mrtu_reply_chk.
//
// Usage:
//  req_ch takes one word per handshake: a read request, a write request, or one
//  received line byte. A request answers with eight frame bytes on rsp_ch
//  (kind 0), CRC low byte first, frame_last on the eighth. The first byte is
//  registered in the accept cycle and one byte follows per cycle while rsp_ch
//  is not stalled; req_ch.ready is low while a frame is going out.
//  A line byte is taken on its handshake; the byte that ends a reply registers
//  one completion word (kind 1) with status and read_value.
//  A new request drops any pending reply. Line bytes while idle give nothing.
//  rsp_ch has one output register: the next word is taken as soon as the held
//  result is being taken; a stalled receiver freezes the frame sequencer and
//  holds req_ch.ready low.
//  Reset (synchronous) empties the result register, stops the sequencer and
//  returns the reply checker to idle.

module modbus_rtu_master_register_access_unit (
   input  logic      clock,
   input  logic      reset,
   mrtu_req_if.sink   req_ch,
   mrtu_rsp_if.source rsp_ch
);

   mrtu_pkg::frame_type      sent_frame_ff, sent_frame_in;
   logic                     tx_busy_ff, tx_busy_in;
   logic [2:0]               tx_idx_ff, tx_idx_in;
   logic [15:0]              tx_crc_ff, tx_crc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   logic                     rsp_last_ff, rsp_last_in;
   mrtu_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [15:0]              rsp_value_ff, rsp_value_in;

   logic                     out_free;
   logic                     accept;
   logic                     is_req;
   logic                     is_write;
   logic [7:0]               tx_pick;
   mrtu_pkg::reply_ctrl_type ctrl;
   mrtu_pkg::reply_done_type done;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = out_free && !tx_busy_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_write     = req_ch.action == mrtu_pkg::ACT_WRITE;
   assign is_req       = accept && (req_ch.action == mrtu_pkg::ACT_READ || is_write);
   assign tx_pick      = sent_frame_ff[tx_idx_ff];

   assign ctrl.start       = is_req;
   assign ctrl.start_write = is_write;
   assign ctrl.rx_strobe   = accept && req_ch.action == mrtu_pkg::ACT_RX;
   assign ctrl.rx_byte     = req_ch.rx_byte;

   mrtu_reply_chk u_reply_chk (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sent_frame (sent_frame_ff),
      .done       (done)
   );

   always_comb begin
      sent_frame_in = sent_frame_ff;
      tx_busy_in    = tx_busy_ff;
      tx_idx_in     = tx_idx_ff;
      tx_crc_in     = tx_crc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (out_free) begin
         rsp_valid_in  = 1'b0;
         rsp_kind_in   = mrtu_pkg::KIND_FRAME;
         rsp_byte_in   = '0;
         rsp_last_in   = 1'b0;
         rsp_status_in = mrtu_pkg::STATUS_OK;
         rsp_value_in  = '0;
         if (is_req) begin
            sent_frame_in[mrtu_pkg::POS_ADDR]   = req_ch.server_address;
            sent_frame_in[mrtu_pkg::POS_FUNC]   = is_write ? mrtu_pkg::FUNC_WRITE
                                                           : mrtu_pkg::FUNC_READ;
            sent_frame_in[mrtu_pkg::POS_REG_HI] = req_ch.register_address[15:8];
            sent_frame_in[mrtu_pkg::POS_REG_LO] = req_ch.register_address[7:0];
            sent_frame_in[mrtu_pkg::POS_VAL_HI] = is_write ? req_ch.write_value[15:8]
                                                           : mrtu_pkg::READ_QTY_HI;
            sent_frame_in[mrtu_pkg::POS_VAL_LO] = is_write ? req_ch.write_value[7:0]
                                                           : mrtu_pkg::READ_QTY_LO;
            // address byte goes out right away, CRC covers every byte up to the one in the output register
            rsp_valid_in = 1'b1;
            rsp_byte_in  = req_ch.server_address;
            tx_busy_in   = 1'b1;
            tx_idx_in    = mrtu_pkg::POS_FUNC;
            tx_crc_in    = mrtu_pkg::crc_byte(mrtu_pkg::CRC_INIT, req_ch.server_address);
         end else if (tx_busy_ff) begin
            rsp_valid_in = 1'b1;
            tx_idx_in    = tx_idx_ff + 3'd1;
            case (tx_idx_ff)
               mrtu_pkg::POS_CRC_LO: begin
                  rsp_byte_in                         = tx_crc_ff[7:0];
                  sent_frame_in[mrtu_pkg::POS_CRC_LO] = tx_crc_ff[7:0];
               end
               mrtu_pkg::POS_CRC_HI: begin
                  rsp_byte_in                         = tx_crc_ff[15:8];
                  sent_frame_in[mrtu_pkg::POS_CRC_HI] = tx_crc_ff[15:8];
                  rsp_last_in                         = 1'b1;
                  tx_busy_in                          = 1'b0;
               end
               default: begin
                  rsp_byte_in = tx_pick;
                  tx_crc_in   = mrtu_pkg::crc_byte(tx_crc_ff, tx_pick);
               end
            endcase
         end else if (done.valid) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = mrtu_pkg::KIND_DONE;
            rsp_status_in = done.status;
            rsp_value_in  = done.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_busy_ff   <= 1'b0;
         tx_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_busy_ff   <= tx_busy_in;
         tx_idx_ff    <= tx_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sent_frame_ff <= sent_frame_in;
      tx_crc_ff     <= tx_crc_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.tx_byte    = rsp_byte_ff;
   assign rsp_ch.frame_last = rsp_last_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      is_req |=> rsp_valid_ff && rsp_kind_ff == mrtu_pkg::KIND_FRAME &&
                 rsp_byte_ff == $past(req_ch.server_address) && tx_busy_ff)
      else $error("request did not start its frame with the address word");

   a_seq_stall: assert property (@(posedge clock) disable iff (reset)
      tx_busy_ff && !out_free |=> $stable(tx_idx_ff) && $stable(tx_crc_ff))
      else $error("frame sequencer advanced while result register was held");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && $past(out_free) |-> !tx_busy_ff &&
                                                         rsp_kind_ff == mrtu_pkg::KIND_FRAME)
      else $error("frame_last word while sequencer still busy");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_value_ff != 16'h0000 |->
         rsp_kind_ff == mrtu_pkg::KIND_DONE && rsp_status_ff == mrtu_pkg::STATUS_OK)
      else $error("read value on a word that is not a good completion");

endmodule
